/* sv/met_pkg.sv */
// Shared types, constants and helper functions for the Mandelbrot escape-time unit.
// Used by every module of the block; has no dependencies of its own.
`default_nettype none

package met_pkg;

    // Field and arithmetic widths.
    localparam int COORD_BITS   = 10;
    localparam int FRAC_BITS    = 28;
    localparam int ITER_BITS    = 10;
    localparam int WORD_BITS    = 32;
    localparam int PROD_BITS    = 2 * WORD_BITS;
    localparam int CNT_BITS     = ITER_BITS + 1;
    localparam int CFG_IDX_BITS = 3;

    // Depth of the queue between the coordinate front end and the iteration core.
    localparam int QDEPTH    = 2;
    localparam int QPTR_BITS = $clog2(QDEPTH);

    // Escape when zr^2 + zi^2 reaches 4.0 in the squared scale.
    localparam logic [PROD_BITS-1:0] ESC_LIMIT = PROD_BITS'(1) << (2 * FRAC_BITS + 2);

    // Register indexes on the configuration port.
    localparam logic [CFG_IDX_BITS-1:0] REG_X_MIN    = CFG_IDX_BITS'(0);
    localparam logic [CFG_IDX_BITS-1:0] REG_X_STEP   = CFG_IDX_BITS'(1);
    localparam logic [CFG_IDX_BITS-1:0] REG_Y_MIN    = CFG_IDX_BITS'(2);
    localparam logic [CFG_IDX_BITS-1:0] REG_Y_STEP   = CFG_IDX_BITS'(3);
    localparam logic [CFG_IDX_BITS-1:0] REG_MAX_ITER = CFG_IDX_BITS'(4);

    // Reset values of the configuration registers.
    localparam logic [WORD_BITS-1:0] X_MIN_RST    = -32'sd536870912;
    localparam logic [WORD_BITS-1:0] X_STEP_RST   = 32'sd559240;
    localparam logic [WORD_BITS-1:0] Y_MIN_RST    = -32'sd268435456;
    localparam logic [WORD_BITS-1:0] Y_STEP_RST   = 32'sd894784;
    localparam logic [ITER_BITS-1:0] MAX_ITER_RST = ITER_BITS'(200);

    typedef struct packed {
        logic [WORD_BITS-1:0] x_min;
        logic [WORD_BITS-1:0] x_step;
        logic [WORD_BITS-1:0] y_min;
        logic [WORD_BITS-1:0] y_step;
    } met_cfg_t;

    typedef struct packed {
        logic [WORD_BITS-1:0] re;
        logic [WORD_BITS-1:0] im;
    } met_point_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SQUARE,
        ST_UPDATE
    } met_state_t;

    // Clamp a wide signed value to the signed word range.
    function automatic logic [WORD_BITS-1:0] sat_word(input logic [PROD_BITS-1:0] v);
        logic [PROD_BITS-WORD_BITS:0] hi;
        hi = v[PROD_BITS-1:WORD_BITS-1];
        if ((&hi) || (~|hi)) begin
            return v[WORD_BITS-1:0];
        end else if (v[PROD_BITS-1]) begin
            return {1'b1, {(WORD_BITS-1){1'b0}}};
        end else begin
            return {1'b0, {(WORD_BITS-1){1'b1}}};
        end
    endfunction

endpackage

`default_nettype wire

/* sv/met_front.sv */
// Front end: accepts pixel coordinates and maps them to the complex point c.
// Two pipeline stages (product, then offset and clamp); depends on met_pkg.
`default_nettype none

module met_front (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire met_pkg::met_cfg_t           cfg,
    input  wire logic                        s_valid,
    output logic                             s_ready,
    input  wire logic [met_pkg::COORD_BITS-1:0] s_pixel_x,
    input  wire logic [met_pkg::COORD_BITS-1:0] s_pixel_y,
    output logic                             c_valid,
    input  wire logic                        c_ready,
    output met_pkg::met_point_t              c_data
);
    import met_pkg::*;

    localparam int PC_BITS  = WORD_BITS + COORD_BITS + 1;
    localparam int SUM_BITS = PC_BITS + 1;

    logic                       en;
    logic                       v1_reg, v1_next;
    logic                       v2_reg, v2_next;
    logic signed [PC_BITS-1:0]  prod_x_reg, prod_x_next;
    logic signed [PC_BITS-1:0]  prod_y_reg, prod_y_next;
    met_point_t                 c_reg, c_next;
    logic signed [SUM_BITS-1:0] sum_x, sum_y;

    // The whole pipeline advances together whenever its last stage can move on.
    assign en      = !v2_reg || c_ready;
    assign s_ready = en;
    assign c_valid = v2_reg;
    assign c_data  = c_reg;

    always_comb begin
        prod_x_next = $signed(cfg.x_step) * $signed({1'b0, s_pixel_x});
        prod_y_next = $signed(cfg.y_step) * $signed({1'b0, s_pixel_y});
        sum_x = SUM_BITS'(prod_x_reg) + SUM_BITS'($signed(cfg.x_min));
        sum_y = SUM_BITS'(prod_y_reg) + SUM_BITS'($signed(cfg.y_min));
        c_next.re = sat_word(PROD_BITS'(sum_x));
        c_next.im = sat_word(PROD_BITS'(sum_y));
        v1_next = en ? s_valid : v1_reg;
        v2_next = en ? v1_reg : v2_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            prod_x_reg <= prod_x_next;
            prod_y_reg <= prod_y_next;
            c_reg      <= c_next;
        end
    end

endmodule

`default_nettype wire

/* sv/met_fifo.sv */
// Short queue of complex points between the front end and the iteration core.
// Register-based, depth set in met_pkg; depends on met_pkg.
`default_nettype none

module met_fifo (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire met_pkg::met_point_t in_data,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output met_pkg::met_point_t      out_data
);
    import met_pkg::*;

    met_point_t           mem [QDEPTH];
    logic [QPTR_BITS-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_BITS-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QPTR_BITS:0]   count_reg, count_next;
    logic                 push, pop;

    assign in_ready  = (count_reg != (QPTR_BITS+1)'(QDEPTH));
    assign out_valid = (count_reg != '0);
    assign out_data  = mem[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= in_data;
        end
    end

endmodule

`default_nettype wire

/* sv/met_core.sv */
// Iteration core: runs z = z*z + c on one point at a time and holds the result.
// Each iteration has a square state, then an update and escape-test state; depends on met_pkg.
`default_nettype none

module met_core (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic [met_pkg::ITER_BITS-1:0] max_iter,
    input  wire logic                        c_valid,
    output logic                             c_ready,
    input  wire met_pkg::met_point_t         c_data,
    output logic                             m_valid,
    input  wire logic                        m_ready,
    output logic [met_pkg::ITER_BITS-1:0]    m_iter_count
);
    import met_pkg::*;

    met_state_t                  state_reg, state_next;
    logic [WORD_BITS-1:0]        cre_reg, cre_next;
    logic [WORD_BITS-1:0]        cim_reg, cim_next;
    logic [WORD_BITS-1:0]        zr_reg, zr_next;
    logic [WORD_BITS-1:0]        zi_reg, zi_next;
    logic signed [PROD_BITS-1:0] rr_reg, rr_next;
    logic signed [PROD_BITS-1:0] ii_reg, ii_next;
    logic signed [PROD_BITS-1:0] ri_reg, ri_next;
    logic [CNT_BITS-1:0]         cnt_reg, cnt_next;
    logic                        out_valid_reg, out_valid_next;
    logic [ITER_BITS-1:0]        out_count_reg, out_count_next;

    logic [PROD_BITS-1:0]        mag;
    logic signed [PROD_BITS-1:0] diff, new_re, new_im;
    logic [CNT_BITS-1:0]         limit;
    logic                        done;

    assign m_valid      = out_valid_reg;
    assign m_iter_count = out_count_reg;

    always_comb begin
        state_next     = state_reg;
        cre_next       = cre_reg;
        cim_next       = cim_reg;
        zr_next        = zr_reg;
        zi_next        = zi_reg;
        rr_next        = rr_reg;
        ii_next        = ii_reg;
        ri_next        = ri_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg;
        out_count_next = out_count_reg;
        c_ready        = 1'b0;

        // Both squares are non-negative, so their sum fits the product width unsigned.
        mag    = $unsigned(rr_reg) + $unsigned(ii_reg);
        limit  = {1'b0, max_iter};
        done   = (mag >= ESC_LIMIT) || (cnt_reg > limit);
        diff   = rr_reg - ii_reg;
        new_re = (diff >>> FRAC_BITS) + PROD_BITS'($signed(cre_reg));
        new_im = (ri_reg >>> (FRAC_BITS - 1)) + PROD_BITS'($signed(cim_reg));

        if (out_valid_reg && m_ready) begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                c_ready = 1'b1;
                if (c_valid) begin
                    cre_next   = c_data.re;
                    cim_next   = c_data.im;
                    zr_next    = '0;
                    zi_next    = '0;
                    cnt_next   = '0;
                    state_next = ST_SQUARE;
                end
            end
            ST_SQUARE: begin
                rr_next    = $signed(zr_reg) * $signed(zr_reg);
                ii_next    = $signed(zi_reg) * $signed(zi_reg);
                ri_next    = $signed(zr_reg) * $signed(zi_reg);
                state_next = ST_UPDATE;
            end
            ST_UPDATE: begin
                if (done) begin
                    // Hold here with the products intact until the output register frees up.
                    if (!out_valid_reg || m_ready) begin
                        out_valid_next = 1'b1;
                        out_count_next = (cnt_reg < limit) ? cnt_reg[ITER_BITS-1:0] : '0;
                        state_next     = ST_IDLE;
                    end
                end else begin
                    zr_next    = sat_word(new_re);
                    zi_next    = sat_word(new_im);
                    cnt_next   = cnt_reg + 1'b1;
                    state_next = ST_SQUARE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cre_reg       <= cre_next;
        cim_reg       <= cim_next;
        zr_reg        <= zr_next;
        zi_reg        <= zi_next;
        rr_reg        <= rr_next;
        ii_reg        <= ii_next;
        ri_reg        <= ri_next;
        cnt_reg       <= cnt_next;
        out_count_reg <= out_count_next;
    end

endmodule

`default_nettype wire

/* sv/mandelbrot_escape_time_unit.sv */
// Top level of the Mandelbrot escape-time unit: configuration registers,
// coordinate front end, point queue and iteration core. Depends on met_pkg,
// met_front, met_fifo and met_core.
//
// Usage: write the window (x_min, x_step, y_min, y_step, Q4.28) and max_iter on
// the configuration port while the unit is idle, then send pixel coordinates on
// the s_ channel. Each transaction yields one escape count on the m_ channel,
// in order; a count that reaches max_iter comes back as zero.
// Path of a pixel: the front end, the queue and the load into the core, then per
// iteration a multiply step and an update and escape-test step, plus the escape
// step. The single iteration core works on one pixel at a time and takes no new
// pixel until it has finished the last, so its square-and-update loop sets the
// pace of the whole unit.
// The front end and queue keep taking coordinates while the core iterates, so
// up to four pixels wait ahead of the core. When the receiver stalls, the result
// stays in the output register and the core finishes its next pixel before it
// stops. Reset (synchronous, active low) empties the pipeline and restores the
// default window with max_iter = 200.
`default_nettype none

module mandelbrot_escape_time_unit (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           cfg_wr_en,
    input  wire logic [met_pkg::CFG_IDX_BITS-1:0] cfg_index,
    input  wire logic [met_pkg::WORD_BITS-1:0]  cfg_wdata,
    input  wire logic                           s_valid,
    output logic                                s_ready,
    input  wire logic [met_pkg::COORD_BITS-1:0] s_pixel_x,
    input  wire logic [met_pkg::COORD_BITS-1:0] s_pixel_y,
    output logic                                m_valid,
    input  wire logic                           m_ready,
    output logic [met_pkg::ITER_BITS-1:0]       m_iter_count
);
    import met_pkg::*;

    met_cfg_t             cfg_reg, cfg_next;
    logic [ITER_BITS-1:0] max_iter_reg, max_iter_next;

    logic       fr_valid, fr_ready;
    met_point_t fr_data;
    logic       q_valid, q_ready;
    met_point_t q_data;

    always_comb begin
        cfg_next      = cfg_reg;
        max_iter_next = max_iter_reg;
        if (cfg_wr_en) begin
            case (cfg_index)
                REG_X_MIN:    cfg_next.x_min  = cfg_wdata;
                REG_X_STEP:   cfg_next.x_step = cfg_wdata;
                REG_Y_MIN:    cfg_next.y_min  = cfg_wdata;
                REG_Y_STEP:   cfg_next.y_step = cfg_wdata;
                REG_MAX_ITER: max_iter_next   = cfg_wdata[ITER_BITS-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.x_min  <= X_MIN_RST;
            cfg_reg.x_step <= X_STEP_RST;
            cfg_reg.y_min  <= Y_MIN_RST;
            cfg_reg.y_step <= Y_STEP_RST;
            max_iter_reg   <= MAX_ITER_RST;
        end else begin
            cfg_reg      <= cfg_next;
            max_iter_reg <= max_iter_next;
        end
    end

    met_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_pixel_x (s_pixel_x),
        .s_pixel_y (s_pixel_y),
        .c_valid   (fr_valid),
        .c_ready   (fr_ready),
        .c_data    (fr_data)
    );

    met_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (fr_valid),
        .in_ready  (fr_ready),
        .in_data   (fr_data),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_data  (q_data)
    );

    met_core u_core (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .max_iter     (max_iter_reg),
        .c_valid      (q_valid),
        .c_ready      (q_ready),
        .c_data       (q_data),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_iter_count (m_iter_count)
    );

endmodule

`default_nettype wire

/* sv/met_checker.sv */
// Port-level checks for the Mandelbrot escape-time unit, bound to its top level.
// Tracks transactions in flight from the ports alone; depends on met_pkg.
`default_nettype none

module met_checker (
    input wire logic                          aclk,
    input wire logic                          aresetn,
    input wire logic                          s_valid,
    input wire logic                          s_ready,
    input wire logic                          m_valid,
    input wire logic                          m_ready,
    input wire logic [met_pkg::ITER_BITS-1:0] m_iter_count
);
    import met_pkg::*;

    // Two front-end stages, the queue, the core and the output register.
    localparam int MAX_INFLIGHT = 2 + QDEPTH + 2;
    localparam int INF_BITS     = $clog2(MAX_INFLIGHT + 2);

    logic [INF_BITS-1:0] inflight_reg, inflight_next;
    logic                in_acc, out_acc;

    assign in_acc  = s_valid && s_ready;
    assign out_acc = m_valid && m_ready;

    always_comb begin
        inflight_next = inflight_reg;
        if (in_acc && !out_acc) begin
            inflight_next = inflight_reg + 1'b1;
        end else if (out_acc && !in_acc) begin
            inflight_next = inflight_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            inflight_reg <= '0;
        end else begin
            inflight_reg <= inflight_next;
        end
    end

    // A stalled result holds its value.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_iter_count))
        else $error("result changed or dropped while stalled");

    // Reset empties the output register.
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    // A result only appears for a pixel that was taken and not yet answered.
    a_no_phantom: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> inflight_reg != '0)
        else $error("result without an outstanding transaction");

    // The pipeline never holds more pixels than it has places for.
    a_capacity: assert property (@(posedge aclk) disable iff (!aresetn)
        inflight_reg <= INF_BITS'(MAX_INFLIGHT))
        else $error("more transactions in flight than the pipeline holds");

endmodule

bind mandelbrot_escape_time_unit met_checker u_met_checker (.*);

`default_nettype wire

/* sim/tb_mandelbrot_escape_time_unit.sv */
// Self-checking testbench for mandelbrot_escape_time_unit: a directed table, then random
// view windows, with an escape-count predictor and an in-order check of every result.
// Depends on met_pkg and the RTL of the unit; nothing else.
`timescale 1ns / 1ps

module tb_mandelbrot_escape_time_unit;
    import met_pkg::*;

    localparam int MAX_SHOWN    = 10;
    localparam int LONG_HOLD    = 400;
    localparam int IDLE_SETTLE  = 4;
    localparam int DRAIN_CAP    = 100000;
    localparam int RANDOM_ITEMS = 2000;
    localparam int REG_SLOTS    = 1 << CFG_IDX_BITS;
    localparam longint WORD_MAX = 64'sd2147483647;
    localparam longint WORD_MIN = -64'sd2147483648;

    typedef enum bit {ROW_WRITE, ROW_PIXEL} row_kind_e;

    typedef struct {
        row_kind_e               kind;
        logic [CFG_IDX_BITS-1:0] reg_idx;
        logic [WORD_BITS-1:0]    value;
        logic [COORD_BITS-1:0]   px;
        logic [COORD_BITS-1:0]   py;
        bit                      known;
        logic [ITER_BITS-1:0]    count;
    } stim_row_t;

    logic                    aclk         = 1'b0;
    logic                    aresetn      = 1'b0;
    logic                    cfg_wr_en    = 1'b0;
    logic [CFG_IDX_BITS-1:0] cfg_index    = '0;
    logic [WORD_BITS-1:0]    cfg_wdata    = '0;
    logic                    s_valid      = 1'b0;
    logic                    s_ready;
    logic [COORD_BITS-1:0]   s_pixel_x    = '0;
    logic [COORD_BITS-1:0]   s_pixel_y    = '0;
    logic                    m_valid;
    logic                    m_ready      = 1'b0;
    logic [ITER_BITS-1:0]    m_iter_count;

    // Copy of the view window and iteration limit as the unit currently holds them.
    longint               win_x_min;
    longint               win_x_step;
    longint               win_y_min;
    longint               win_y_step;
    logic [ITER_BITS-1:0] win_max_iter;

    logic [ITER_BITS-1:0] pending_counts[$];
    stim_row_t            directed_rows[$];

    int          failures       = 0;
    int          results_seen   = 0;
    int          hold_left      = 0;
    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;

    mandelbrot_escape_time_unit DUT (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_pixel_x    (s_pixel_x),
        .s_pixel_y    (s_pixel_y),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_iter_count (m_iter_count)
    );

    initial begin
        forever #1 aclk = ~aclk;
    end

    initial begin
        #20_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    function automatic longint clamp_word(input longint v);
        if (v > WORD_MAX) begin
            return WORD_MAX;
        end else if (v < WORD_MIN) begin
            return WORD_MIN;
        end
        return v;
    endfunction

    function automatic logic [ITER_BITS-1:0] escape_count(input logic [COORD_BITS-1:0] px,
                                                          input logic [COORD_BITS-1:0] py);
        longint               c_re;
        longint               c_im;
        longint               zr;
        longint               zi;
        longint               rr;
        longint               ii;
        longint               re_next;
        logic [PROD_BITS-1:0] mag;
        int unsigned          steps;
        c_re  = clamp_word(win_x_min + longint'(px) * win_x_step);
        c_im  = clamp_word(win_y_min + longint'(py) * win_y_step);
        zr    = 0;
        zi    = 0;
        steps = 0;
        forever begin
            rr  = zr * zr;
            ii  = zi * zi;
            // Two squares of -2^31 add up to 2^63, so the sum is taken as unsigned.
            mag = rr + ii;
            if ((mag >> FRAC_BITS) >= (PROD_BITS'(4) << FRAC_BITS) || steps > win_max_iter) begin
                break;
            end
            re_next = clamp_word(((rr - ii) >>> FRAC_BITS) + c_re);
            zi      = clamp_word(((zr * zi) >>> (FRAC_BITS - 1)) + c_im);
            zr      = re_next;
            steps++;
        end
        return (steps < win_max_iter) ? ITER_BITS'(steps) : '0;
    endfunction

    function automatic void log_failure(input string what);
        if (failures < MAX_SHOWN) begin
            $display("ERROR: %s", what);
        end
        failures++;
    endfunction

    function automatic void add_write(input logic [CFG_IDX_BITS-1:0] idx,
                                      input logic [WORD_BITS-1:0] value);
        directed_rows.push_back('{ROW_WRITE, idx, value, '0, '0, 1'b0, '0});
    endfunction

    function automatic void add_pixel(input logic [COORD_BITS-1:0] px,
                                      input logic [COORD_BITS-1:0] py);
        directed_rows.push_back('{ROW_PIXEL, '0, '0, px, py, 1'b0, '0});
    endfunction

    function automatic void add_known(input logic [COORD_BITS-1:0] px,
                                      input logic [COORD_BITS-1:0] py,
                                      input logic [ITER_BITS-1:0] count);
        directed_rows.push_back('{ROW_PIXEL, '0, '0, px, py, 1'b1, count});
    endfunction

    task automatic set_traffic(input int mode);
        case (mode)
            0: begin
                send_idle_pct  = 0;
                recv_stall_pct = 0;
            end
            1: begin
                send_idle_pct  = 73;
                recv_stall_pct = 0;
            end
            2: begin
                send_idle_pct  = 0;
                recv_stall_pct = 73;
            end
            default: begin
                send_idle_pct  = 35;
                recv_stall_pct = 35;
            end
        endcase
    endtask

    task automatic drain_results();
        int waited;
        waited = 0;
        s_valid <= 1'b0;
        while (pending_counts.size() != 0 && waited < DRAIN_CAP) begin
            @(posedge aclk);
            waited++;
        end
        repeat (IDLE_SETTLE) @(posedge aclk);
    endtask

    // Registers change only with nothing in flight.
    task automatic cfg_write(input logic [CFG_IDX_BITS-1:0] idx,
                             input logic [WORD_BITS-1:0] value);
        if (s_valid || pending_counts.size() != 0) begin
            drain_results();
        end
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
        case (idx)
            REG_X_MIN:    win_x_min    = longint'(signed'(value));
            REG_X_STEP:   win_x_step   = longint'(signed'(value));
            REG_Y_MIN:    win_y_min    = longint'(signed'(value));
            REG_Y_STEP:   win_y_step   = longint'(signed'(value));
            REG_MAX_ITER: win_max_iter = value[ITER_BITS-1:0];
            default: ;
        endcase
    endtask

    task automatic send_pixel(input logic [COORD_BITS-1:0] px, input logic [COORD_BITS-1:0] py,
                              input bit known, input logic [ITER_BITS-1:0] count);
        cfg_wr_en <= 1'b0;
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_pixel_x <= px;
        s_pixel_y <= py;
        do @(posedge aclk); while (!s_ready);
        pending_counts.push_back(known ? count : escape_count(px, py));
    endtask

    task automatic random_window(output int items);
        logic [WORD_BITS-1:0] word;
        int unsigned          roll;
        roll = $urandom_range(99);
        if (roll < 15) begin
            // Whole-word windows: mostly saturated points that escape on the first step.
            cfg_write(REG_X_MIN, $urandom());
            cfg_write(REG_X_STEP, $urandom());
            cfg_write(REG_Y_MIN, $urandom());
            cfg_write(REG_Y_STEP, $urandom());
        end else begin
            // Frames around the set: real part from -2.5, imaginary part from -1.5.
            cfg_write(REG_X_MIN, $urandom_range(805306368) - 32'd671088640);
            word = $urandom_range(1 << 20);
            if ($urandom_range(3) == 0) begin
                word = -word;
            end
            cfg_write(REG_X_STEP, word);
            cfg_write(REG_Y_MIN, $urandom_range(536870912) - 32'd402653184);
            word = $urandom_range(1 << 20);
            if ($urandom_range(3) == 0) begin
                word = -word;
            end
            cfg_write(REG_Y_STEP, word);
        end
        // Upper bits of the limit write are random and must be dropped by the unit.
        roll = $urandom_range(99);
        word = $urandom();
        if (roll < 4) begin
            word[ITER_BITS-1:0] = '1;
        end else if (roll < 8) begin
            word[ITER_BITS-1:0] = ITER_BITS'($urandom_range(1));
        end else if (roll < 18) begin
            word[ITER_BITS-1:0] = ITER_BITS'($urandom_range(300, 49));
        end else begin
            word[ITER_BITS-1:0] = ITER_BITS'($urandom_range(48, 1));
        end
        cfg_write(REG_MAX_ITER, word);
        items = (win_max_iter > 300) ? 8 : $urandom_range(80, 20);
    endtask

    always @(posedge aclk) begin : result_check
        logic [ITER_BITS-1:0] want;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                results_seen++;
                if (pending_counts.size() == 0) begin
                    log_failure($sformatf("result %0d (iter_count %0d) with no transaction pending",
                                          results_seen, m_iter_count));
                end else begin
                    want = pending_counts.pop_front();
                    if (m_iter_count !== want) begin
                        log_failure($sformatf("result %0d: expected iter_count %0d, got %0d",
                                              results_seen, want, m_iter_count));
                    end
                end
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    initial begin : stimulus
        int items;
        int sent;
        int win;
        win_x_min    = longint'(signed'(X_MIN_RST));
        win_x_step   = longint'(signed'(X_STEP_RST));
        win_y_min    = longint'(signed'(Y_MIN_RST));
        win_y_step   = longint'(signed'(Y_STEP_RST));
        win_max_iter = MAX_ITER_RST;

        // Window after reset: both corners lie outside radius two and escape at once.
        add_known(0, 0, 1);
        add_known('1, '1, 1);
        add_pixel('1, 0);
        add_pixel(0, '1);
        add_pixel(960, 300);
        add_pixel(512, 512);
        add_pixel(700, 500);
        // Writes to indexes past the last register must leave the window alone.
        for (int idx = REG_MAX_ITER + 1; idx < REG_SLOTS; idx++) begin
            add_write(CFG_IDX_BITS'(idx), $urandom());
        end
        add_pixel(960, 300);
        // c = 0 everywhere with the largest limit: the longest run, answered as zero.
        add_write(REG_X_MIN, '0);
        add_write(REG_X_STEP, '0);
        add_write(REG_Y_MIN, '0);
        add_write(REG_Y_STEP, '0);
        add_write(REG_MAX_ITER, '1);
        add_known('1, '1, 0);
        // A limit of zero still takes one step and answers zero; a limit of one answers zero too.
        add_write(REG_MAX_ITER, '0);
        add_known(0, 0, 0);
        add_write(REG_MAX_ITER, 32'd1);
        add_known(5, 5, 0);
        // |c| exactly two escapes on the first step, on both axes.
        add_write(REG_MAX_ITER, 32'd2);
        add_write(REG_X_MIN, 32'hE000_0000);
        add_known(0, 0, 1);
        add_write(REG_X_MIN, '0);
        add_write(REG_Y_MIN, 32'h2000_0000);
        add_known(7, 9, 1);
        // Coordinates far out of range saturate c at both ends of the word.
        add_write(REG_X_MIN, 32'h7FFF_FFFF);
        add_write(REG_X_STEP, 32'h7FFF_FFFF);
        add_write(REG_Y_MIN, 32'h7FFF_FFFF);
        add_write(REG_Y_STEP, 32'h7FFF_FFFF);
        add_known('1, '1, 1);
        add_write(REG_X_MIN, 32'h8000_0000);
        add_write(REG_X_STEP, 32'h8000_0000);
        add_write(REG_Y_MIN, 32'h8000_0000);
        add_write(REG_Y_STEP, 32'h8000_0000);
        add_known('1, '1, 1);
        add_known(0, 0, 1);
        // One step inside the left tip of the set.
        add_write(REG_X_MIN, 32'hE000_0001);
        add_write(REG_X_STEP, 32'd1);
        add_write(REG_Y_MIN, '0);
        add_write(REG_Y_STEP, 32'd1);
        add_write(REG_MAX_ITER, 32'd200);
        add_pixel(0, 0);
        add_pixel('1, '1);

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        set_traffic(0);
        foreach (directed_rows[k]) begin
            if (directed_rows[k].kind == ROW_WRITE) begin
                cfg_write(directed_rows[k].reg_idx, directed_rows[k].value);
            end else begin
                send_pixel(directed_rows[k].px, directed_rows[k].py,
                           directed_rows[k].known, directed_rows[k].count);
            end
        end

        sent = 0;
        win  = 0;
        while (sent < RANDOM_ITEMS) begin
            random_window(items);
            set_traffic(win % 4);
            // The receiver holds off while the sender keeps going, so the unit backs up.
            if (win == 4) begin
                hold_left = LONG_HOLD;
            end
            for (int k = 0; k < items; k++) begin
                if (win == 6 && k == items / 2) begin
                    drain_results();
                end
                send_pixel(COORD_BITS'($urandom()), COORD_BITS'($urandom()), 1'b0, '0);
            end
            sent += items;
            win++;
        end

        drain_results();
        repeat (2 * win_max_iter + 8) @(posedge aclk);
        if (pending_counts.size() != 0) begin
            log_failure($sformatf("%0d transactions never answered", pending_counts.size()));
        end
        if (failures == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
